// ===== hw/rtl/nasb_pkg.sv =====
// nasb_pkg: shared types and constants of the narrow access shadow bridge
// no dependencies; imported by nasb_settle_div, narrow_access_shadow_bridge and the test bench
`timescale 1ns / 1ps
`default_nettype none

package nasb_pkg;

  // controller register offsets that get special treatment
  localparam logic [15:0] OFF_BLK_SIZE  = 16'h0004;
  localparam logic [15:0] OFF_BLK_COUNT = 16'h0006;
  localparam logic [15:0] OFF_XFER_MODE = 16'h000C;
  localparam logic [15:0] OFF_COMMAND   = 16'h000E;

  // access size codes
  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;

  // lane masks
  localparam logic [31:0] LANE_BYTE = 32'h0000_00FF;
  localparam logic [31:0] LANE_HALF = 32'h0000_FFFF;

  // settle delay: ceil(SETTLE_NUM / clk) for 0 < clk <= CLK_SLOW_MAX
  localparam int          SETTLE_W     = 22;
  localparam int          DVD_W        = 23;
  localparam int          DVS_W        = 19;
  localparam int          HZ_W         = 28;
  localparam logic [HZ_W-1:0] CLK_SLOW_MAX = 28'd400000;
  localparam logic [DVD_W-1:0] SETTLE_NUM  = 23'd4000000;
  localparam logic [SETTLE_W-1:0] SETTLE_CLK_OFF = 22'd10;

  // one result of an access, as held before it goes out
  typedef struct packed {
    logic        is_write;
    logic [31:0] rdata;
    logic [7:0]  addr;
    logic [31:0] wdata;
    logic        last;
  } res_t;

  // lane merge of a narrow value into an old dword
  function automatic logic [31:0] lane_merge(input logic [31:0] old_word,
                                             input logic [31:0] lane_mask,
                                             input logic [31:0] val,
                                             input logic [4:0]  shift);
    logic [31:0] mask;
    mask = lane_mask << shift;
    return (old_word & ~mask) | ((val & lane_mask) << shift);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/narrow_access_shadow_bridge.sv =====
// narrow_access_shadow_bridge: top level, narrow register access to 32-bit writes
// depends on nasb_pkg and nasb_settle_div
`timescale 1ns / 1ps
`default_nettype none

// Takes byte, halfword and word register requests and turns them into
// results for a controller that only accepts aligned 32-bit accesses: one
// read result, one or two 32-bit writes, or nothing when a halfword write
// only lands in the block or transfer-mode shadow. A halfword write to the
// command register flushes the block shadow first (if pending), then writes
// transfer mode and command together. Every write result carries the settle
// delay for the current sd clock. A slow clock value (up to 400 kHz) loaded
// through cfg_wr_en is divided by a restoring divider, one quotient bit per
// cycle, and in_tready stays low while the division runs; a clock of zero
// or above 400 kHz takes effect at once with no stall. A request is taken
// when in_tready is high, and each of its results then sits in the output
// register until the sink takes it; a request that leaves only shadow state
// behind has no result. in_tready is low while results of the previous
// request are still waiting.
module narrow_access_shadow_bridge
  import nasb_pkg::*;
#(
  parameter int OFFSET_BITS = 8,
  localparam int IN_BITS  = 2 + OFFSET_BITS + 64,
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_BITS = 32 + 8 + 32 + SETTLE_W,
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
  input  wire logic clk,
  input  wire logic rst_n,

  // request channel
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  // access_size[1:0], reg_offset, write_value, backing_word, zero fill
  input  wire logic [IN_W-1:0]     in_tdata,
  // cmd: 0 read, 1 write
  input  wire logic                in_tuser,

  // result channel
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  // read_data[31:0], out_addr[39:32], out_data[71:40], settle_us[93:72], zero fill
  output logic [OUT_W-1:0]         out_tdata,
  // is_write_out
  output logic                     out_tuser,
  // last_result
  output logic                     out_tlast,

  // sd clock register
  input  wire logic                cfg_wr_en,
  input  wire logic [HZ_W-1:0]     cfg_wr_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_OUT0,
    S_OUT1
  } state_t;

  // request fields
  logic [1:0]             in_size;
  logic [OFFSET_BITS-1:0] in_off;
  logic [31:0]            in_wval;
  logic [31:0]            in_back;

  state_t       state_r, state_nxt;
  res_t         res0_r, res0_nxt;
  res_t         res1_r, res1_nxt;
  logic [31:0]  blk_shadow_r, blk_shadow_nxt;
  logic         blk_pend_r, blk_pend_nxt;
  logic [31:0]  xfer_shadow_r, xfer_shadow_nxt;
  logic         xfer_pend_r, xfer_pend_nxt;

  logic         div_busy;
  logic [SETTLE_W-1:0] settle_us;

  logic         in_acc;
  logic         out_acc;
  res_t         cur;

  assign in_size = in_tdata[1:0];
  assign in_off  = in_tdata[2 +: OFFSET_BITS];
  assign in_wval = in_tdata[2 + OFFSET_BITS +: 32];
  assign in_back = in_tdata[34 + OFFSET_BITS +: 32];

  nasb_settle_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cfg_wr_en),
    .clk_hz    (cfg_wr_data),
    .busy      (div_busy),
    .settle_us (settle_us)
  );

  assign in_tready = (state_r == S_IDLE) && !div_busy;
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;

  // decode a request and build its results in the same cycle it is taken
  always_comb begin
    logic [15:0] off;
    logic [4:0]  shift;
    logic [7:0]  addr;
    logic [31:0] src;
    logic [31:0] old_word;
    logic        is_blk;
    res_t        rd;
    res_t        wr;

    off      = 16'(in_off);
    shift    = {off[1:0], 3'b000};
    addr     = {off[7:2], 2'b00};
    is_blk   = (off == OFF_BLK_SIZE) || (off == OFF_BLK_COUNT);
    src      = in_back;
    old_word = in_back;
    rd       = '0;
    wr       = '0;

    state_nxt       = state_r;
    res0_nxt        = res0_r;
    res1_nxt        = res1_r;
    blk_shadow_nxt  = blk_shadow_r;
    blk_pend_nxt    = blk_pend_r;
    xfer_shadow_nxt = xfer_shadow_r;
    xfer_pend_nxt   = xfer_pend_r;

    rd.last     = 1'b1;
    wr.is_write = 1'b1;
    wr.last     = 1'b1;
    wr.addr     = addr;

    if (in_acc) begin
      state_nxt = S_OUT0;
      if (!in_tuser) begin
        // read: pick the lane, halfwords of shadowed registers may come from a shadow
        case (in_size)
          SIZE_BYTE: rd.rdata = (in_back >> shift) & LANE_BYTE;
          SIZE_HALF: begin
            if (off == OFF_XFER_MODE && xfer_pend_r) begin
              src = xfer_shadow_r;
            end else if (is_blk && blk_pend_r) begin
              src = blk_shadow_r;
            end
            rd.rdata = (src >> shift) & LANE_HALF;
          end
          default: rd.rdata = in_back;
        endcase
        res0_nxt = rd;
      end else begin
        case (in_size)
          SIZE_BYTE: begin
            wr.wdata = lane_merge(in_back, LANE_BYTE, in_wval, shift);
            res0_nxt = wr;
          end
          SIZE_HALF: begin
            if (off == OFF_COMMAND) begin
              // flush: block shadow first if pending, then transfer mode + command
              old_word      = xfer_pend_r ? xfer_shadow_r : in_back;
              wr.addr       = OFF_XFER_MODE[7:0];
              wr.wdata      = lane_merge(old_word, LANE_HALF, in_wval, shift);
              blk_pend_nxt  = 1'b0;
              xfer_pend_nxt = 1'b0;
              if (blk_pend_r) begin
                res0_nxt.is_write = 1'b1;
                res0_nxt.rdata    = '0;
                res0_nxt.addr     = OFF_BLK_SIZE[7:0];
                res0_nxt.wdata    = blk_shadow_r;
                res0_nxt.last     = 1'b0;
                res1_nxt          = wr;
              end else begin
                res0_nxt = wr;
              end
            end else if (is_blk) begin
              old_word       = blk_pend_r ? blk_shadow_r : in_back;
              blk_shadow_nxt = lane_merge(old_word, LANE_HALF, in_wval, shift);
              blk_pend_nxt   = 1'b1;
              state_nxt      = S_IDLE;
            end else if (off == OFF_XFER_MODE) begin
              old_word        = xfer_pend_r ? xfer_shadow_r : in_back;
              xfer_shadow_nxt = lane_merge(old_word, LANE_HALF, in_wval, shift);
              xfer_pend_nxt   = 1'b1;
              state_nxt       = S_IDLE;
            end else begin
              wr.wdata = lane_merge(in_back, LANE_HALF, in_wval, shift);
              res0_nxt = wr;
            end
          end
          default: begin
            // word write passes through untouched
            wr.wdata = in_wval;
            res0_nxt = wr;
          end
        endcase
      end
    end else if (out_acc) begin
      case (state_r)
        S_OUT0:  state_nxt = res0_r.last ? S_IDLE : S_OUT1;
        S_OUT1:  state_nxt = S_IDLE;
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      blk_shadow_r  <= '0;
      blk_pend_r    <= 1'b0;
      xfer_shadow_r <= '0;
      xfer_pend_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      blk_shadow_r  <= blk_shadow_nxt;
      blk_pend_r    <= blk_pend_nxt;
      xfer_shadow_r <= xfer_shadow_nxt;
      xfer_pend_r   <= xfer_pend_nxt;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    res0_r <= res0_nxt;
    res1_r <= res1_nxt;
  end

  // output mux: second result only after a block shadow flush
  assign cur        = (state_r == S_OUT1) ? res1_r : res0_r;
  assign out_tvalid = (state_r != S_IDLE);
  assign out_tuser  = cur.is_write;
  assign out_tlast  = cur.last;
  assign out_tdata  = OUT_W'({(cur.is_write ? settle_us : SETTLE_W'(0)),
                              cur.wdata, cur.addr, cur.rdata});

  // a request and its results never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid && !div_busy)
    else $error("request taken while busy");

  // the last result hands control back to the request side
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready || div_busy)
    else $error("bridge stuck after last result");

  // a command write leaves no shadow pending
  a_cmd_flush: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tuser && in_size == SIZE_HALF && 16'(in_off) == OFF_COMMAND
    |=> !blk_pend_r && !xfer_pend_r)
    else $error("shadow still pending after command write");

  // a second result only follows a non-final first one
  a_two_results: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT1 |-> !res0_r.last && res1_r.last && res1_r.is_write)
    else $error("bad second result");

endmodule

`default_nettype wire

// ===== hw/rtl/nasb_settle_div.sv =====
// nasb_settle_div: settle delay from the sd clock, one quotient bit per cycle
// depends on nasb_pkg
`timescale 1ns / 1ps
`default_nettype none

module nasb_settle_div
  import nasb_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [HZ_W-1:0]     clk_hz,
  output logic                     busy,
  output logic [SETTLE_W-1:0]      settle_us
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  typedef enum logic {
    D_IDLE,
    D_RUN
  } dstate_t;

  dstate_t              state_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DVD_W-1:0]     dvd_r;
  logic [DVS_W-1:0]     dvs_r;
  logic [DVS_W-1:0]     rem_r;
  logic [SETTLE_W-1:0]  settle_r;

  logic [DVS_W:0]       trial;
  logic                 qbit;
  logic [DVS_W:0]       diff;

  always_comb begin
    trial = {rem_r, dvd_r[DVD_W-1]};
    qbit  = trial >= {1'b0, dvs_r};
    diff  = trial - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= D_IDLE;
      cnt_r    <= '0;
      settle_r <= SETTLE_CLK_OFF;
    end else if (start) begin
      // a new clock value restarts any division in flight
      if (clk_hz == '0) begin
        state_r  <= D_IDLE;
        settle_r <= SETTLE_CLK_OFF;
      end else if (clk_hz > CLK_SLOW_MAX) begin
        state_r  <= D_IDLE;
        settle_r <= '0;
      end else begin
        state_r <= D_RUN;
        cnt_r   <= CNT_W'(DVD_W);
        dvd_r   <= SETTLE_NUM + DVD_W'(clk_hz) - DVD_W'(1);
        dvs_r   <= clk_hz[DVS_W-1:0];
        rem_r   <= '0;
      end
    end else if (state_r == D_RUN) begin
      rem_r <= qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      dvd_r <= {dvd_r[DVD_W-2:0], qbit};
      cnt_r <= cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        state_r  <= D_IDLE;
        settle_r <= {dvd_r[SETTLE_W-2:0], qbit};
      end
    end
  end

  assign busy      = (state_r == D_RUN);
  assign settle_us = settle_r;

  // remainder stays below the divisor while dividing
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == D_RUN |-> rem_r < dvs_r)
    else $error("divider remainder out of range");

  a_cnt_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == D_RUN |-> cnt_r != '0)
    else $error("divider running with empty count");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == D_RUN && cnt_r == CNT_W'(1) && !start |=> state_r == D_IDLE)
    else $error("divider did not finish");

endmodule

`default_nettype wire

// ===== test/narrow_access_shadow_bridge_test.sv =====
// narrow_access_shadow_bridge_test: self-checking bench for the narrow access shadow bridge
// drives random and directed register requests and checks every result against its own predictor
// depends on nasb_pkg and narrow_access_shadow_bridge
`timescale 1ns / 1ps

module narrow_access_shadow_bridge_test;
  import nasb_pkg::*;

  // port widths, packed as the block documents them
  localparam int IN_W  = 80;  // size 2 + offset 8 + write value 32 + backing 32, zero fill
  localparam int OUT_W = 96;  // read 32 + addr 8 + write data 32 + settle 22, zero fill

  localparam int LIMIT_CYCLES = 300000;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 110;

  // request kinds and the two sizes the package leaves out
  localparam bit       CMD_READ  = 1'b0;
  localparam bit       CMD_WRITE = 1'b1;
  localparam bit [1:0] SIZE_WORD = 2'd2;
  localparam bit [1:0] SIZE_WIDE = 2'd3;  // behaves as a word

  // 8-bit views of the special register offsets
  localparam bit [7:0] A_BLK_SIZE  = OFF_BLK_SIZE[7:0];
  localparam bit [7:0] A_BLK_COUNT = OFF_BLK_COUNT[7:0];
  localparam bit [7:0] A_XFER_MODE = OFF_XFER_MODE[7:0];
  localparam bit [7:0] A_COMMAND   = OFF_COMMAND[7:0];

  typedef struct {
    bit        wr;
    bit [1:0]  size;
    bit [7:0]  off;
    bit [31:0] wval;
    bit [31:0] back;
  } access_t;

  typedef struct {
    bit        is_wr;
    bit [31:0] rdata;
    bit [7:0]  addr;
    bit [31:0] wdata;
    bit [21:0] settle;
    bit        last;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             in_tuser = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;
  logic             out_tuser;
  logic             out_tlast;
  logic             cfg_wr_en = 1'b0;
  logic [HZ_W-1:0]  cfg_wr_data = '0;

  narrow_access_shadow_bridge uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // requests waiting to go out, and results the bridge still owes us
  access_t access_queue[$];
  result_t due_results[$];
  access_t cur_access;

  // predictor copy of the bridge state
  bit [27:0] sd_hz = '0;
  bit [31:0] blk_shadow = '0;
  bit        blk_pend = 1'b0;
  bit [31:0] xfer_shadow = '0;
  bit        xfer_pend = 1'b0;

  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  bit          rx_hold = 1'b0;
  bit          rx_hold_go = 1'b0;

  int n_sent = 0;
  int n_accepted = 0;
  int n_checked = 0;
  int n_reads = 0;
  int n_writes = 0;
  int n_absorbed = 0;
  int n_flush = 0;
  int errors = 0;
  int cycle_count = 0;

  // settle time for the sd clock currently loaded
  function automatic bit [21:0] settle_for_clock();
    bit [31:0] q;
    if (sd_hz == '0) return SETTLE_CLK_OFF;
    if (sd_hz <= CLK_SLOW_MAX) begin
      q = ({9'b0, SETTLE_NUM} + {4'b0, sd_hz} - 32'd1) / {4'b0, sd_hz};
      return q[21:0];
    end
    return '0;
  endfunction

  // drop a narrow lane into a dword; lane bits shifted past bit 31 fall off
  function automatic bit [31:0] splice(bit [31:0] old, bit [31:0] lane, bit [31:0] val,
                                       bit [4:0] sh);
    bit [31:0] m;
    bit [31:0] v;
    m = lane << sh;
    v = (val & lane) << sh;
    return (old & ~m) | v;
  endfunction

  function automatic void owe_write(bit [7:0] addr, bit [31:0] data, bit last);
    result_t r;
    r = '{default: 0};
    r.is_wr = 1'b1;
    r.addr = addr & 8'hFC;
    r.wdata = data;
    r.settle = settle_for_clock();
    r.last = last;
    due_results.push_back(r);
  endfunction

  // what one accepted request turns into at the controller side
  function automatic void translate_access(access_t a);
    result_t   r;
    bit [4:0]  sh;
    bit [31:0] src;
    bit        blk_reg;
    sh = {a.off[1:0], 3'b000};
    blk_reg = (a.off == A_BLK_SIZE) || (a.off == A_BLK_COUNT);
    if (a.wr == CMD_READ) begin
      n_reads++;
      r = '{default: 0};
      r.last = 1'b1;
      if (a.size == SIZE_BYTE) begin
        r.rdata = (a.back >> sh) & LANE_BYTE;
      end else if (a.size == SIZE_HALF) begin
        src = a.back;
        if (a.off == A_XFER_MODE && xfer_pend) src = xfer_shadow;
        else if (blk_reg && blk_pend) src = blk_shadow;
        r.rdata = (src >> sh) & LANE_HALF;
      end else begin
        r.rdata = a.back;
      end
      due_results.push_back(r);
      return;
    end
    n_writes++;
    if (a.size == SIZE_BYTE) begin
      owe_write(a.off, splice(a.back, LANE_BYTE, a.wval, sh), 1'b1);
    end else if (a.size != SIZE_HALF) begin
      owe_write(a.off, a.wval, 1'b1);
    end else if (a.off == A_COMMAND) begin
      // command flushes block shadow first, then mode plus command together
      if (blk_pend) begin
        owe_write(A_BLK_SIZE, blk_shadow, 1'b0);
        blk_pend = 1'b0;
        n_flush++;
      end
      src = xfer_pend ? xfer_shadow : a.back;
      xfer_pend = 1'b0;
      owe_write(A_XFER_MODE, splice(src, LANE_HALF, a.wval, sh), 1'b1);
    end else if (blk_reg) begin
      blk_shadow = splice(blk_pend ? blk_shadow : a.back, LANE_HALF, a.wval, sh);
      blk_pend = 1'b1;
      n_absorbed++;
    end else if (a.off == A_XFER_MODE) begin
      xfer_shadow = splice(xfer_pend ? xfer_shadow : a.back, LANE_HALF, a.wval, sh);
      xfer_pend = 1'b1;
      n_absorbed++;
    end else begin
      owe_write(a.off, splice(a.back, LANE_HALF, a.wval, sh), 1'b1);
    end
  endfunction

  function automatic void push_access(bit wr, bit [1:0] size, bit [7:0] off,
                                      bit [31:0] wval, bit [31:0] back);
    access_t a;
    a.wr = wr;
    a.size = size;
    a.off = off;
    a.wval = wval;
    a.back = back;
    access_queue.push_back(a);
  endfunction

  // offsets near the shadowed registers get most of the traffic
  function automatic bit [7:0] pick_offset();
    bit [7:0] near[10];
    near = '{A_BLK_SIZE, A_BLK_COUNT, A_XFER_MODE, A_COMMAND, 8'h05, 8'h07,
             8'h0D, 8'h0F, 8'h00, 8'h08};
    if ($urandom_range(99) < 50) return near[$urandom_range(9)];
    return 8'($urandom_range(255));
  endfunction

  function automatic bit [31:0] pick_word();
    case ($urandom_range(9))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic void push_noise();
    bit [1:0] sz;
    sz = ($urandom_range(9) == 0) ? SIZE_WIDE : 2'($urandom_range(2));
    push_access(1'($urandom_range(1)), sz, pick_offset(), pick_word(), pick_word());
  endfunction

  // block and mode setup followed (usually) by the command write that flushes it
  function automatic int push_transfer_setup();
    int n;
    int k;
    bit [7:0] rd_off[3];
    n = 0;
    rd_off = '{A_BLK_SIZE, A_BLK_COUNT, A_XFER_MODE};
    k = $urandom_range(1, 3);
    repeat (k) begin
      push_access(CMD_WRITE, SIZE_HALF, $urandom_range(1) ? A_BLK_COUNT : A_BLK_SIZE,
                  pick_word(), pick_word());
      n++;
    end
    if ($urandom_range(99) < 70) begin
      push_access(CMD_WRITE, SIZE_HALF, A_XFER_MODE, pick_word(), pick_word());
      n++;
    end
    k = $urandom_range(2);
    repeat (k) begin
      if ($urandom_range(3) == 0) push_noise();
      else push_access(CMD_READ, SIZE_HALF, rd_off[$urandom_range(2)], $urandom, pick_word());
      n++;
    end
    // sometimes leave the shadows pending on purpose
    if ($urandom_range(99) < 80) begin
      push_access(CMD_WRITE, SIZE_HALF, A_COMMAND, pick_word(), pick_word());
      n++;
    end
    return n;
  endfunction

  // request driver: one new request per free slot, with random gaps
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || n_accepted == n_sent) begin
      if (access_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
        cur_access = access_queue.pop_front();
        in_tdata <= {6'b0, cur_access.back, cur_access.wval, cur_access.off, cur_access.size};
        in_tuser <= cur_access.wr;
        in_tvalid <= 1'b1;
        n_sent++;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result sink: random back-pressure plus the long hold-off
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= !rx_hold && ($urandom_range(99) >= recv_idle);
  end

  // the long hold-off, counted here so the sender keeps going meanwhile
  initial begin
    wait (rx_hold_go);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk);
    rx_hold = 1'b0;
  end

  task automatic check_field(string name, bit [31:0] want, bit [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch on %s: expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // monitor: predict on request handshake, compare on result handshake
  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        translate_access(cur_access);
        n_accepted++;
      end
      if (out_tvalid && out_tready) begin
        if (due_results.size() == 0) begin
          $display("%0t unexpected result: expected none, actual write=%0b tdata=%h",
                   $time, out_tuser, out_tdata);
          errors++;
        end else begin
          want = due_results.pop_front();
          check_field("is_write", want.is_wr, out_tuser);
          check_field("read_data", want.rdata, out_tdata[31:0]);
          check_field("addr", want.addr, out_tdata[39:32]);
          check_field("write_data", want.wdata, out_tdata[71:40]);
          check_field("settle_us", want.settle, out_tdata[93:72]);
          check_field("last", want.last, out_tlast);
          n_checked++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("narrow_access_shadow_bridge_test NOT OK");
      $finish;
    end
  end

  // everything sent, taken and answered, then idle clocks so shadow-only requests settle
  task automatic drain();
    while (access_queue.size() != 0 || n_accepted != n_sent || due_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic load_sd_clock(bit [27:0] hz);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= hz;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sd_hz = hz;
  endtask

  initial begin
    bit [27:0] clock_plan[9];
    int ph;
    int cnt;
    clock_plan = '{28'd1, 28'd400000, 28'd3, 28'd208000000, 28'hFFFFFFF, 28'd399999,
                   28'd400001, 28'd0, 28'd0};
    clock_plan[8] = 28'($urandom_range(1, 400000));

    send_idle = 28;
    recv_idle = 51;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed requests at the reset clock setting (clock off)
    push_access(CMD_READ, SIZE_BYTE, 8'h00, 32'h0, 32'hA5C3_0F81);
    push_access(CMD_READ, SIZE_BYTE, 8'h03, 32'h0, 32'hA5C3_0F81);
    push_access(CMD_READ, SIZE_HALF, 8'h03, 32'h0, 32'hFFFF_FFFF);  // only the top byte
    push_access(CMD_READ, SIZE_WORD, 8'hFF, 32'h0, 32'hFFFF_FFFF);
    push_access(CMD_READ, SIZE_WIDE, 8'h81, 32'h0, 32'h1234_5678);
    push_access(CMD_WRITE, SIZE_BYTE, 8'hFF, 32'hFFFF_FFFF, 32'h0);
    push_access(CMD_WRITE, SIZE_HALF, 8'h02, 32'hFFFF_FFFF, 32'h0);
    push_access(CMD_WRITE, SIZE_HALF, 8'h03, 32'hFFFF_ABCD, 32'h0);
    push_access(CMD_WRITE, SIZE_WORD, 8'hFE, 32'hDEAD_BEEF, 32'h0);
    push_access(CMD_WRITE, SIZE_WIDE, 8'h10, 32'h0, 32'hFFFF_FFFF);
    push_access(CMD_READ, SIZE_HALF, A_BLK_SIZE, 32'h0, 32'h1111_2222);  // nothing pending
    push_access(CMD_WRITE, SIZE_HALF, A_BLK_SIZE, 32'h0000_0200, 32'h5555_AAAA);
    push_access(CMD_WRITE, SIZE_HALF, A_BLK_COUNT, 32'h0000_0010, 32'h0);
    push_access(CMD_READ, SIZE_HALF, A_BLK_SIZE, 32'h0, 32'hFFFF_FFFF);   // from shadow
    push_access(CMD_READ, SIZE_HALF, A_BLK_COUNT, 32'h0, 32'hFFFF_FFFF);
    push_access(CMD_READ, SIZE_BYTE, A_BLK_SIZE, 32'h0, 32'h7766_5544);   // bypasses shadow
    push_access(CMD_WRITE, SIZE_HALF, A_XFER_MODE, 32'h0000_0037, 32'h9999_0000);
    push_access(CMD_READ, SIZE_HALF, A_XFER_MODE, 32'h0, 32'h0);
    push_access(CMD_WRITE, SIZE_WORD, A_XFER_MODE, 32'h0BAD_F00D, 32'h0);  // no shadow effect
    push_access(CMD_WRITE, SIZE_HALF, A_COMMAND, 32'h0000_123A, 32'hFFFF_FFFF);  // two writes
    push_access(CMD_READ, SIZE_HALF, A_XFER_MODE, 32'h0, 32'hCAFE_0042);
    push_access(CMD_WRITE, SIZE_HALF, A_COMMAND, 32'h0000_0C1B, 32'h00FF_00FF);  // one write
    push_access(CMD_WRITE, SIZE_HALF, A_XFER_MODE, 32'h0000_FFFF, 32'h0);
    push_access(CMD_WRITE, SIZE_HALF, A_COMMAND, 32'hFFFF_0000, 32'h0);
    push_access(CMD_WRITE, SIZE_BYTE, A_COMMAND, 32'h0000_005A, 32'h0102_0304);
    drain();

    for (ph = 0; ph < 9; ph++) begin
      if (ph < 3) begin
        send_idle = 28;
        recv_idle = 51;
      end else if (ph < 6) begin
        send_idle = 51;
        recv_idle = 28;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      load_sd_clock(clock_plan[ph]);
      // mostly well-formed setup/command sequences, the rest loose noise
      cnt = 0;
      while (cnt < PHASE_ITEMS) begin
        if ($urandom_range(99) < 60) begin
          cnt += push_transfer_setup();
        end else begin
          push_noise();
          cnt++;
        end
      end
      if (ph == 1) rx_hold_go = 1'b1;
      drain();
    end

    repeat (10) @(posedge clk);
    $display("covered %0d requests: %0d reads, %0d writes, %0d held in shadows, %0d flushes",
             n_accepted, n_reads, n_writes, n_absorbed, n_flush);
    $display("checked %0d results across 10 sd clock settings, with back-pressure and a long sink stall",
             n_checked);
    if (errors == 0) begin
      $display("narrow_access_shadow_bridge_test OK");
    end else begin
      $display("narrow_access_shadow_bridge_test NOT OK");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/nasb_pkg.sv
hw/rtl/nasb_settle_div.sv
hw/rtl/narrow_access_shadow_bridge.sv
test/narrow_access_shadow_bridge_test.sv
